// ===== hdl/bkit_pkg.sv =====
// Shared types and constants for the bucketed key index table.
// Used by the channel interfaces, the controller, the datapath and the top level.
package bkit_pkg;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned IDX_W       = 9;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned BUCKET_W    = 8;
  localparam int unsigned NUM_BUCKETS = 256;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT_RD,
    ST_DECIDE,
    ST_SCAN,
    ST_FINISH
  } ctl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic latch;
    logic cnt_rd;
    logic clear_all;
    logic ins_wr;
    logic mark_full;
    logic scan_init;
    logic scan_step;
    logic load_out;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_e  op;
    logic n_zero;
    logic n_full;
    logic hit;
    logic miss;
    logic out_free;
  } ctl_sts_t;

  // Bucket number: key bits 15..12 above key bits 3..0.
  function automatic logic [BUCKET_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
    return {key[15:12], key[3:0]};
  endfunction

endpackage

// ===== hdl/bkit_in_if.sv =====
// Input channel of the bucketed key index table: valid/ready plus the request.
// Depends on bkit_pkg for field widths.
interface bkit_in_if;
  logic                       valid;
  logic                       ready;
  logic [bkit_pkg::OP_W-1:0]  op;
  logic [bkit_pkg::KEY_W-1:0] key;
  logic [bkit_pkg::IDX_W-1:0] item_index;

  modport source (output valid, output op, output key, output item_index, input ready);
  modport sink   (input valid, input op, input key, input item_index, output ready);
endinterface

// ===== hdl/bkit_out_if.sv =====
// Output channel of the bucketed key index table: valid/ready plus the result.
// Depends on bkit_pkg for field widths.
interface bkit_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [bkit_pkg::IDX_W-1:0] result_index;
  logic                       bucket_full;

  modport source (output valid, output found, output result_index, output bucket_full,
                  input ready);
  modport sink   (input valid, input found, input result_index, input bucket_full,
                  output ready);
endinterface

// ===== hdl/bucketed_key_index_table.sv =====
// Bucketed key index table: maps 32-bit keys to 9-bit indices in 256 buckets of
// BUCKET_CAPACITY entries, bucket chosen by key bits 15..12 over key bits 3..0.
// One request is worked at a time and gives one result. A clear, an insert or an
// unused opcode passes through count read, decide and finish; a lookup of a bucket
// holding n entries also scans them (stopping early on a match), bounded by the
// entry memory's single read port, which the scan reads one entry per cycle. A new
// request may be taken while the previous result still waits in the output register.
// Clear is instant: per-bucket valid bits reset every count at once, no clearing pass.
module bucketed_key_index_table #(
  parameter int unsigned BUCKET_CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bkit_in_if.sink     in_i,
  bkit_out_if.source  out_o
);

  bkit_pkg::ctl_cmd_t cmd;
  bkit_pkg::ctl_sts_t sts;

  bkit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bkit_dpath #(
    .BUCKET_CAPACITY (BUCKET_CAPACITY)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (in_i.op),
    .key_i          (in_i.key),
    .item_index_i   (in_i.item_index),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .found_o        (out_o.found),
    .result_index_o (out_o.result_index),
    .bucket_full_o  (out_o.bucket_full)
  );

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken again right after a transfer");

  a_hit_miss_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_step |-> !(sts.hit && sts.miss))
    else $error("scan reports hit and miss together");

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins_wr |-> !sts.n_full)
    else $error("insert written into a full bucket");

  a_result_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (!(out_o.found && out_o.bucket_full) &&
                     (out_o.found || (out_o.result_index == '0))))
    else $error("inconsistent result fields");
`endif

endmodule

// ===== hdl/bkit_ctrl.sv =====
// Controller state machine of the bucketed key index table.
// Depends on bkit_pkg; drives datapath commands from datapath status.
module bkit_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bkit_pkg::ctl_sts_t sts_i,
  output bkit_pkg::ctl_cmd_t cmd_o
);

  bkit_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bkit_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      bkit_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = bkit_pkg::ST_CNT_RD;
        end
      end
      bkit_pkg::ST_CNT_RD: begin
        cmd_o.cnt_rd = 1'b1;
        state_d      = bkit_pkg::ST_DECIDE;
      end
      bkit_pkg::ST_DECIDE: begin
        state_d = bkit_pkg::ST_FINISH;
        case (sts_i.op)
          bkit_pkg::OP_CLEAR: begin
            cmd_o.clear_all = 1'b1;
          end
          bkit_pkg::OP_INSERT: begin
            if (sts_i.n_full) begin
              cmd_o.mark_full = 1'b1;
            end else begin
              cmd_o.ins_wr = 1'b1;
            end
          end
          bkit_pkg::OP_LOOKUP: begin
            if (!sts_i.n_zero) begin
              cmd_o.scan_init = 1'b1;
              state_d         = bkit_pkg::ST_SCAN;
            end
          end
          default: begin
            state_d = bkit_pkg::ST_FINISH;
          end
        endcase
      end
      bkit_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit || sts_i.miss) begin
          state_d = bkit_pkg::ST_FINISH;
        end
      end
      bkit_pkg::ST_FINISH: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = bkit_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bkit_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/bkit_dpath.sv =====
// Datapath of the bucketed key index table: bucket counts, entry memory,
// scan pipeline and output register. Depends on bkit_pkg; driven by bkit_ctrl.
module bkit_dpath #(
  parameter int unsigned BUCKET_CAPACITY = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bkit_pkg::ctl_cmd_t           cmd_i,
  output bkit_pkg::ctl_sts_t           sts_o,
  input  logic [bkit_pkg::OP_W-1:0]    op_i,
  input  logic [bkit_pkg::KEY_W-1:0]   key_i,
  input  logic [bkit_pkg::IDX_W-1:0]   item_index_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic                         found_o,
  output logic [bkit_pkg::IDX_W-1:0]   result_index_o,
  output logic                         bucket_full_o
);

  localparam int unsigned CNT_W       = $clog2(BUCKET_CAPACITY + 1);
  localparam int unsigned TABLE_DEPTH = bkit_pkg::NUM_BUCKETS * BUCKET_CAPACITY;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned ENTRY_W     = bkit_pkg::KEY_W + bkit_pkg::IDX_W;

  // Request registers
  logic [bkit_pkg::OP_W-1:0]  op_q;
  logic [bkit_pkg::KEY_W-1:0] key_q;
  logic [bkit_pkg::IDX_W-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= op_i;
      key_q <= key_i;
      idx_q <= item_index_i;
    end
  end

  logic [bkit_pkg::BUCKET_W-1:0] bucket;
  logic [ADDR_W-1:0]             base;
  assign bucket = bkit_pkg::bucket_of(key_q);
  assign base   = ADDR_W'(bucket) * ADDR_W'(BUCKET_CAPACITY);

  // Bucket counts: memory plus one valid bit per bucket, cleared at once
  logic [CNT_W-1:0]                  cnt_mem [bkit_pkg::NUM_BUCKETS];
  logic [bkit_pkg::NUM_BUCKETS-1:0]  bkt_vld_q;
  logic [CNT_W-1:0]                  cnt_rd_q;
  logic                              vld_rd_q;
  logic [CNT_W-1:0]                  n;

  assign n = vld_rd_q ? cnt_rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_rd) begin
      cnt_rd_q <= cnt_mem[bucket];
    end
    if (cmd_i.ins_wr) begin
      cnt_mem[bucket] <= n + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bkt_vld_q <= '0;
      vld_rd_q  <= 1'b0;
    end else begin
      if (cmd_i.cnt_rd) begin
        vld_rd_q <= bkt_vld_q[bucket];
      end
      if (cmd_i.clear_all) begin
        bkt_vld_q <= '0;
      end else if (cmd_i.ins_wr) begin
        bkt_vld_q[bucket] <= 1'b1;
      end
    end
  end

  // Entry memory, one read port and one write port
  logic [ENTRY_W-1:0]         entry_mem [TABLE_DEPTH];
  logic [CNT_W-1:0]           slot_q;
  logic                       pend_q;
  logic                       issue;
  logic [ADDR_W-1:0]          rd_addr;
  logic [ADDR_W-1:0]          wr_addr;
  logic [bkit_pkg::KEY_W-1:0] rd_key_q;
  logic [bkit_pkg::IDX_W-1:0] rd_idx_q;
  logic                       match;

  assign issue   = cmd_i.scan_step && (slot_q < n);
  assign rd_addr = base + ADDR_W'(slot_q);
  assign wr_addr = base + ADDR_W'(n);
  assign match   = (rd_key_q == key_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_wr) begin
      entry_mem[wr_addr] <= {key_q, idx_q};
    end
    if (issue) begin
      {rd_key_q, rd_idx_q} <= entry_mem[rd_addr];
    end
  end

  // Scan: issue one read a cycle, compare the previous read's data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.scan_init) begin
      slot_q <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      pend_q <= issue;
      if (issue) begin
        slot_q <= slot_q + CNT_W'(1);
      end
    end
  end

  logic hit, miss;
  assign hit  = pend_q && match;
  assign miss = (slot_q == n) && !hit;

  // Result under construction
  logic                       res_found_q;
  logic [bkit_pkg::IDX_W-1:0] res_idx_q;
  logic                       res_full_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      res_found_q <= 1'b0;
      res_idx_q   <= '0;
      res_full_q  <= 1'b0;
    end else begin
      if (cmd_i.scan_step && hit) begin
        res_found_q <= 1'b1;
        res_idx_q   <= rd_idx_q;
      end
      if (cmd_i.mark_full) begin
        res_full_q <= 1'b1;
      end
    end
  end

  // Output register
  logic                       out_valid_q;
  logic                       out_found_q;
  logic [bkit_pkg::IDX_W-1:0] out_idx_q;
  logic                       out_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_found_q <= res_found_q;
      out_idx_q   <= res_idx_q;
      out_full_q  <= res_full_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign result_index_o = out_idx_q;
  assign bucket_full_o  = out_full_q;

  assign sts_o.op       = bkit_pkg::op_e'(op_q);
  assign sts_o.n_zero   = (n == '0);
  assign sts_o.n_full   = (n == CNT_W'(BUCKET_CAPACITY));
  assign sts_o.hit      = hit;
  assign sts_o.miss     = miss;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule
